### rtl/rcsb_pkg.sv
// Shared types, constants and arithmetic helpers of the RGB channel shift blit unit.
`default_nettype none
package rcsb_pkg;

	localparam int COORD_W = 12;
	localparam int OFF_W   = 13;
	localparam int DIM_W   = 13;
	localparam int PIX_W   = 8;
	localparam int LANE_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 13;
	localparam int MOD_W   = 13;
	localparam int SUM_W   = 14;
	localparam int PROD_W  = 16;

	localparam int MAX_DIM = 4096;
	localparam int MOD_CAP = (MAX_DIM > (2 ** DIM_W) - 1) ? (2 ** DIM_W) - 1 : MAX_DIM;
	localparam logic [MOD_W-1:0] MOD_MAX = MOD_W'(MOD_CAP);

	localparam int QUEUE_DEPTH = 4;

	// Division by 255 as a multiply by a rounded-up reciprocal and a shift.
	localparam logic [PROD_W-1:0] RECIP_255 = 16'd32897;
	localparam int RECIP_SHIFT = 23;
	localparam logic [PROD_W-1:0] ROUND_BIAS = 16'd127;

	localparam logic [LANE_W-1:0] LANE_BLUE  = 2'd0;
	localparam logic [LANE_W-1:0] LANE_GREEN = 2'd1;
	localparam logic [LANE_W-1:0] LANE_RED   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_RED_DX       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RED_DY       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_DX     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_DY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_DX      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_DY      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

	typedef struct packed {
		logic [OFF_W-1:0] red_dx;
		logic [OFF_W-1:0] red_dy;
		logic [OFF_W-1:0] green_dx;
		logic [OFF_W-1:0] green_dy;
		logic [OFF_W-1:0] blue_dx;
		logic [OFF_W-1:0] blue_dy;
	} offsets_t;

	typedef struct packed {
		logic [MOD_W-1:0]  ux;
		logic              negx;
		logic [MOD_W-1:0]  uy;
		logic              negy;
		logic [PIX_W-1:0]  color;
		logic [PIX_W-1:0]  alpha;
		logic [LANE_W-1:0] lane;
		logic              last;
	} job_t;

	typedef struct packed {
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic [LANE_W-1:0]  channel;
		logic [PIX_W-1:0]   value;
		logic               last;
	} res_t;

	// One restoring step of an unsigned remainder by the wrap modulus.
	function automatic logic [MOD_W-1:0] mod_step(input logic [MOD_W-1:0] rem,
		input logic b, input logic [MOD_W-1:0] m);
		logic [MOD_W:0] t;
		t = {rem, b};
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		return t[MOD_W-1:0];
	endfunction

	// One restoring division step by alpha; the top bit is the quotient bit.
	function automatic logic [PIX_W:0] div_step(input logic [PIX_W-1:0] rem,
		input logic b, input logic [PIX_W-1:0] a);
		logic [PIX_W:0] t;
		t = {rem, b};
		if (t >= {1'b0, a}) begin
			t = t - {1'b0, a};
			return {1'b1, t[PIX_W-1:0]};
		end
		return {1'b0, t[PIX_W-1:0]};
	endfunction

endpackage
`default_nettype wire

### rtl/rcsb_ifs.sv
// Handshake interfaces for pixel words, result words and configuration writes.
`default_nettype none
interface rcsb_pixel_if;
	logic                          valid;
	logic                          ready;
	logic [rcsb_pkg::COORD_W-1:0]  pixel_x;
	logic [rcsb_pkg::COORD_W-1:0]  pixel_y;
	logic [rcsb_pkg::PIX_W-1:0]    red_in;
	logic [rcsb_pkg::PIX_W-1:0]    green_in;
	logic [rcsb_pkg::PIX_W-1:0]    blue_in;
	logic [rcsb_pkg::PIX_W-1:0]    alpha_in;
	modport source(output valid, pixel_x, pixel_y, red_in, green_in, blue_in, alpha_in,
		input ready);
	modport sink(input valid, pixel_x, pixel_y, red_in, green_in, blue_in, alpha_in,
		output ready);
endinterface

interface rcsb_result_if;
	logic                          valid;
	logic                          ready;
	logic [rcsb_pkg::COORD_W-1:0]  dest_x;
	logic [rcsb_pkg::COORD_W-1:0]  dest_y;
	logic [rcsb_pkg::LANE_W-1:0]   channel;
	logic [rcsb_pkg::PIX_W-1:0]    value;
	logic                          last;
	modport source(output valid, dest_x, dest_y, channel, value, last, input ready);
	modport sink(input valid, dest_x, dest_y, channel, value, last, output ready);
endinterface

interface rcsb_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rcsb_pkg::CFG_IDX_W-1:0]  index;
	logic [rcsb_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/rgb_channel_shift_blit_unit.sv
// Top level of the RGB channel shift blit unit: configuration registers, front, queue, back.
// Each pixel word yields three channel words (red, green, blue) on one result port.
// One channel word per cycle leaves the back pipeline unless the result port stalls.
// A new pixel is taken as the last job of the one before enters the queue.
// Reset clears the configuration to zero offsets and a 4096 by 4096 frame and empties all stages.
`default_nettype none
module rgb_channel_shift_blit_unit #(
	parameter int QUEUE_DEPTH = rcsb_pkg::QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	rcsb_pixel_if.sink    pixel,
	rcsb_result_if.source result,
	rcsb_cfg_if.sink      cfg
);
	rcsb_pkg::offsets_t               offs_q;
	logic [rcsb_pkg::DIM_W-1:0]       width_q;
	logic [rcsb_pkg::DIM_W-1:0]       height_q;
	logic [rcsb_pkg::MOD_W-1:0]       mod_x;
	logic [rcsb_pkg::MOD_W-1:0]       mod_y;
	logic                             fj_valid, fj_ready, bj_valid, bj_ready;
	rcsb_pkg::job_t                   fj, bj;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offs_q   <= '0;
			width_q  <= rcsb_pkg::DIM_W'(4096);
			height_q <= rcsb_pkg::DIM_W'(4096);
		end else if (cfg.valid) begin
			case (cfg.index)
				rcsb_pkg::REG_RED_DX:       offs_q.red_dx   <= cfg.data;
				rcsb_pkg::REG_RED_DY:       offs_q.red_dy   <= cfg.data;
				rcsb_pkg::REG_GREEN_DX:     offs_q.green_dx <= cfg.data;
				rcsb_pkg::REG_GREEN_DY:     offs_q.green_dy <= cfg.data;
				rcsb_pkg::REG_BLUE_DX:      offs_q.blue_dx  <= cfg.data;
				rcsb_pkg::REG_BLUE_DY:      offs_q.blue_dy  <= cfg.data;
				rcsb_pkg::REG_FRAME_WIDTH:  width_q         <= cfg.data;
				rcsb_pkg::REG_FRAME_HEIGHT: height_q        <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// A zero size wraps as one, a size above the maximum wraps at the maximum.
	always_comb begin
		if (width_q == '0) begin
			mod_x = rcsb_pkg::MOD_W'(1);
		end else if (width_q > rcsb_pkg::MOD_MAX) begin
			mod_x = rcsb_pkg::MOD_MAX;
		end else begin
			mod_x = width_q;
		end
		if (height_q == '0) begin
			mod_y = rcsb_pkg::MOD_W'(1);
		end else if (height_q > rcsb_pkg::MOD_MAX) begin
			mod_y = rcsb_pkg::MOD_MAX;
		end else begin
			mod_y = height_q;
		end
	end

	rcsb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.offs      (offs_q),
		.job_valid (fj_valid),
		.job_ready (fj_ready),
		.job       (fj)
	);

	rcsb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fj_valid),
		.push_ready (fj_ready),
		.push_job   (fj),
		.pop_valid  (bj_valid),
		.pop_ready  (bj_ready),
		.pop_job    (bj)
	);

	rcsb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bj_valid),
		.job_ready (bj_ready),
		.job       (bj),
		.mod_x     (mod_x),
		.mod_y     (mod_y),
		.result    (result)
	);
endmodule
`default_nettype wire

### rtl/rcsb_front.sv
// Front end: accepts pixel words and splits each into red, green and blue channel jobs.
`default_nettype none
module rcsb_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	rcsb_pixel_if.sink              pixel,
	input  wire rcsb_pkg::offsets_t offs,
	output logic                    job_valid,
	input  wire logic               job_ready,
	output rcsb_pkg::job_t          job
);
	logic                            hold_q;
	logic [rcsb_pkg::LANE_W-1:0]     lane_q;
	logic [rcsb_pkg::COORD_W-1:0]    px_q;
	logic [rcsb_pkg::COORD_W-1:0]    py_q;
	logic [rcsb_pkg::PIX_W-1:0]      r_q;
	logic [rcsb_pkg::PIX_W-1:0]      g_q;
	logic [rcsb_pkg::PIX_W-1:0]      b_q;
	logic [rcsb_pkg::PIX_W-1:0]      a_q;
	logic [rcsb_pkg::PIX_W-1:0]      color;
	logic [rcsb_pkg::OFF_W-1:0]      dx;
	logic [rcsb_pkg::OFF_W-1:0]      dy;
	logic [rcsb_pkg::SUM_W-1:0]      sx;
	logic [rcsb_pkg::SUM_W-1:0]      sy;
	logic                            is_last;
	logic                            take;
	logic                            push;

	assign is_last     = (lane_q == rcsb_pkg::LANE_BLUE);
	assign push        = hold_q && job_ready;
	assign pixel.ready = !hold_q || (push && is_last);
	assign take        = pixel.valid && pixel.ready;

	always_comb begin
		case (lane_q)
			rcsb_pkg::LANE_RED: begin
				color = r_q;
				dx    = offs.red_dx;
				dy    = offs.red_dy;
			end
			rcsb_pkg::LANE_GREEN: begin
				color = g_q;
				dx    = offs.green_dx;
				dy    = offs.green_dy;
			end
			default: begin
				color = b_q;
				dx    = offs.blue_dx;
				dy    = offs.blue_dy;
			end
		endcase
	end

	// A negative sum s is folded to -s-1, which is its bitwise inverse.
	assign sx = {2'b00, px_q} + {dx[rcsb_pkg::OFF_W-1], dx};
	assign sy = {2'b00, py_q} + {dy[rcsb_pkg::OFF_W-1], dy};

	always_comb begin
		job.negx  = sx[rcsb_pkg::SUM_W-1];
		job.negy  = sy[rcsb_pkg::SUM_W-1];
		job.ux    = sx[rcsb_pkg::SUM_W-1] ? ~sx[rcsb_pkg::MOD_W-1:0] : sx[rcsb_pkg::MOD_W-1:0];
		job.uy    = sy[rcsb_pkg::SUM_W-1] ? ~sy[rcsb_pkg::MOD_W-1:0] : sy[rcsb_pkg::MOD_W-1:0];
		job.color = color;
		job.alpha = a_q;
		job.lane  = lane_q;
		job.last  = is_last;
	end

	assign job_valid = hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			lane_q <= rcsb_pkg::LANE_RED;
		end else begin
			if (take) begin
				hold_q <= 1'b1;
				lane_q <= rcsb_pkg::LANE_RED;
			end else if (push) begin
				if (is_last) begin
					hold_q <= 1'b0;
				end else begin
					lane_q <= lane_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			px_q <= pixel.pixel_x;
			py_q <= pixel.pixel_y;
			r_q  <= pixel.red_in;
			g_q  <= pixel.green_in;
			b_q  <= pixel.blue_in;
			a_q  <= pixel.alpha_in;
		end
	end
endmodule
`default_nettype wire

### rtl/rcsb_queue.sv
// Short job queue between the front end and the arithmetic back end.
`default_nettype none
module rcsb_queue #(
	parameter int DEPTH = rcsb_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire rcsb_pkg::job_t push_job,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output rcsb_pkg::job_t      pop_job
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rcsb_pkg::job_t     mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               push;
	logic               pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end
endmodule
`default_nettype wire

### rtl/rcsb_back.sv
// Back end: pipelined coordinate wrap and alpha reweighting, one channel word per cycle unless the result port stalls.
`default_nettype none
module rcsb_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        job_valid,
	output logic                             job_ready,
	input  wire rcsb_pkg::job_t              job,
	input  wire logic [rcsb_pkg::MOD_W-1:0]  mod_x,
	input  wire logic [rcsb_pkg::MOD_W-1:0]  mod_y,
	rcsb_result_if.source                    result
);
	localparam int MW = rcsb_pkg::MOD_W;
	localparam int PW = rcsb_pkg::PIX_W;
	localparam int A_LO = MW - 4;
	localparam int B_LO = MW - 8;
	localparam int C_LO = 1;
	localparam int DIV_MID = PW / 2;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	rcsb_pkg::res_t out_q;

	logic [MW-1:0] ux_s1, uy_s1, ux_s2, uy_s2, ux_s3, uy_s3;
	logic [MW-1:0] rx_s1, ry_s1, rx_s2, ry_s2, rx_s3, ry_s3;
	logic          negx_s1, negy_s1, negx_s2, negy_s2, negx_s3, negy_s3;
	logic [rcsb_pkg::LANE_W-1:0] lane_s1, lane_s2, lane_s3, lane_s4;
	logic          last_s1, last_s2, last_s3, last_s4;
	logic [PW-1:0] a_s1, a_s2, a_s3;
	logic          sat_s1, sat_s2;
	logic [PW-1:0] drem_s1, drem_s2, dlow_s1, dlow_s2, q_s2, u_s3;
	logic [rcsb_pkg::COORD_W-1:0] dx_s4, dy_s4;
	logic [rcsb_pkg::PROD_W-1:0]  p_s4;

	logic [MW-1:0] rx_a, ry_a, rx_b, ry_b, rx_c, ry_c, rx_d, ry_d, fx_d, fy_d;
	logic [rcsb_pkg::PROD_W-1:0] n_a;
	logic [PW-1:0] dr_b, q_b, dr_c, q_c;
	logic [PW:0]   t_b, t_c;
	logic [rcsb_pkg::PROD_W-1:0] p_d;
	logic [2*rcsb_pkg::PROD_W-1:0] prod_e;

	assign en        = !out_valid_q || result.ready;
	assign job_ready = en;

	always_comb begin
		rx_a = '0;
		ry_a = '0;
		for (int i = MW - 1; i >= A_LO; i--) begin
			rx_a = rcsb_pkg::mod_step(rx_a, job.ux[i], mod_x);
			ry_a = rcsb_pkg::mod_step(ry_a, job.uy[i], mod_y);
		end
		n_a = ({job.color, 8'd0} - {8'd0, job.color}) + {9'd0, job.alpha[PW-1:1]};
	end

	always_comb begin
		rx_b = rx_s1;
		ry_b = ry_s1;
		for (int i = A_LO - 1; i >= B_LO; i--) begin
			rx_b = rcsb_pkg::mod_step(rx_b, ux_s1[i], mod_x);
			ry_b = rcsb_pkg::mod_step(ry_b, uy_s1[i], mod_y);
		end
		dr_b = drem_s1;
		q_b  = '0;
		for (int j = PW - 1; j >= DIV_MID; j--) begin
			t_b    = rcsb_pkg::div_step(dr_b, dlow_s1[j], a_s1);
			dr_b   = t_b[PW-1:0];
			q_b[j] = t_b[PW];
		end
	end

	always_comb begin
		rx_c = rx_s2;
		ry_c = ry_s2;
		for (int i = B_LO - 1; i >= C_LO; i--) begin
			rx_c = rcsb_pkg::mod_step(rx_c, ux_s2[i], mod_x);
			ry_c = rcsb_pkg::mod_step(ry_c, uy_s2[i], mod_y);
		end
		dr_c = drem_s2;
		q_c  = q_s2;
		for (int j = DIV_MID - 1; j >= 0; j--) begin
			t_c    = rcsb_pkg::div_step(dr_c, dlow_s2[j], a_s2);
			dr_c   = t_c[PW-1:0];
			q_c[j] = t_c[PW];
		end
	end

	always_comb begin
		rx_d = rcsb_pkg::mod_step(rx_s3, ux_s3[0], mod_x);
		ry_d = rcsb_pkg::mod_step(ry_s3, uy_s3[0], mod_y);
		fx_d = negx_s3 ? (mod_x - 1'b1 - rx_d) : rx_d;
		fy_d = negy_s3 ? (mod_y - 1'b1 - ry_d) : ry_d;
		p_d  = ({8'd0, u_s3} * {8'd0, a_s3}) + rcsb_pkg::ROUND_BIAS;
	end

	assign prod_e = {16'd0, p_s4} * {16'd0, rcsb_pkg::RECIP_255};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= job_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1   <= job.ux;
			uy_s1   <= job.uy;
			negx_s1 <= job.negx;
			negy_s1 <= job.negy;
			rx_s1   <= rx_a;
			ry_s1   <= ry_a;
			lane_s1 <= job.lane;
			last_s1 <= job.last;
			a_s1    <= job.alpha;
			sat_s1  <= (n_a[15:8] >= job.alpha);
			drem_s1 <= n_a[15:8];
			dlow_s1 <= n_a[7:0];

			ux_s2   <= ux_s1;
			uy_s2   <= uy_s1;
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
			rx_s2   <= rx_b;
			ry_s2   <= ry_b;
			lane_s2 <= lane_s1;
			last_s2 <= last_s1;
			a_s2    <= a_s1;
			sat_s2  <= sat_s1;
			drem_s2 <= dr_b;
			dlow_s2 <= dlow_s1;
			q_s2    <= q_b;

			ux_s3   <= ux_s2;
			uy_s3   <= uy_s2;
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
			rx_s3   <= rx_c;
			ry_s3   <= ry_c;
			lane_s3 <= lane_s2;
			last_s3 <= last_s2;
			a_s3    <= a_s2;
			u_s3    <= sat_s2 ? 8'hFF : q_c;

			dx_s4   <= fx_d[rcsb_pkg::COORD_W-1:0];
			dy_s4   <= fy_d[rcsb_pkg::COORD_W-1:0];
			lane_s4 <= lane_s3;
			last_s4 <= last_s3;
			p_s4    <= p_d;

			out_q.dest_x  <= dx_s4;
			out_q.dest_y  <= dy_s4;
			out_q.channel <= lane_s4;
			out_q.last    <= last_s4;
			out_q.value   <= prod_e[rcsb_pkg::RECIP_SHIFT+PW-1:rcsb_pkg::RECIP_SHIFT];
		end
	end

	assign result.valid   = out_valid_q;
	assign result.dest_x  = out_q.dest_x;
	assign result.dest_y  = out_q.dest_y;
	assign result.channel = out_q.channel;
	assign result.value   = out_q.value;
	assign result.last    = out_q.last;
endmodule
`default_nettype wire
